// ===== src/rpcst_pkg.sv =====
// shared types and constants for the permutation range checker
`timescale 1ns / 1ps
package rpcst_pkg;

  localparam int FIELD_W = 11;
  localparam int HASH_W  = 64;
  localparam logic [HASH_W-1:0] HASH_BASE = 64'd11;

  localparam logic OPC_UPDATE = 1'b0;
  localparam logic OPC_QUERY  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] position_or_left;
    logic [FIELD_W-1:0] value_or_right;
  } rpcst_in_t;

  typedef struct packed {
    logic is_permutation;
    logic range_error;
  } rpcst_out_t;

  // controller to datapath strobes
  typedef struct packed {
    logic init_step;
    logic latch_in;
    logic decode;
    logic leaf_wr;
    logic up_rd;
    logic up_wr;
    logic q_rd;
    logic q_acc;
    logic fin;
    logic cmp;
    logic load_out;
  } rpcst_cmd_t;

  // datapath to controller flags
  typedef struct packed {
    logic init_last;
    logic err;
    logic is_query;
    logic node_zero;
    logic range_empty;
    logic out_free;
  } rpcst_sts_t;

endpackage

// ===== src/range_permutation_check_segment_tree_unit.sv =====
// top level of the permutation range checker
`timescale 1ns / 1ps
// Keeps a bottom-up segment tree of 2*MAX_ELEMENTS nodes; each node holds the
// plain sum of its range and the sum of 11^value mod 2^64. An update item
// (opcode 0) writes one position and rebuilds its ancestors; a query item
// (opcode 1) over [left,right] sums the covering nodes and reports whether the
// slice is a permutation of 1..k. Every item gives exactly one result item.
// After reset the block runs a clearing pass over every tree node, which
// zeroes the tree and fills the power and prefix tables; in_ready stays low
// meanwhile. Items are then handled one at a time: an update writes its leaf
// and rebuilds each ancestor up to the root, a query walks the tree level by
// level until its range is empty, and an item with a range error goes straight
// to the result. Each tree level takes a read state then an add state, as the
// tree memories are read into registers ahead of each add. Results sit in an
// output register, so a new item is taken while a result waits. element_count
// may be written at any time the block is idle; writes of 0 become 1 and large
// values saturate to MAX_ELEMENTS.
module range_permutation_check_segment_tree_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rpcst_pkg::rpcst_in_t          in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rpcst_pkg::rpcst_out_t         out_item,
  input  logic                          cfg_we,
  input  logic [rpcst_pkg::FIELD_W-1:0] cfg_wdata
);
  import rpcst_pkg::*;

  rpcst_cmd_t cmd;
  rpcst_sts_t sts;

  // sequencer
  rpcst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories and arithmetic
  rpcst_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== src/rpcst_ctrl.sv =====
// sequencer for init sweep, updates and range queries
`timescale 1ns / 1ps
module rpcst_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rpcst_pkg::rpcst_sts_t sts,
  output rpcst_pkg::rpcst_cmd_t cmd
);
  import rpcst_pkg::*;

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DECODE = 11'b000_0000_0100,
    S_LEAF   = 11'b000_0000_1000,
    S_UP_RD  = 11'b000_0001_0000,
    S_UP_WR  = 11'b000_0010_0000,
    S_Q_RD   = 11'b000_0100_0000,
    S_Q_ACC  = 11'b000_1000_0000,
    S_FIN    = 11'b001_0000_0000,
    S_CMP    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.err) state_nxt = S_DONE;
        else if (sts.is_query) state_nxt = S_Q_RD;
        else state_nxt = S_LEAF;
      end
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_nxt   = S_UP_RD;
      end
      S_UP_RD: begin
        if (sts.node_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.up_wr = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_Q_RD: begin
        if (sts.range_empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        cmd.q_acc = 1'b1;
        state_nxt = S_Q_RD;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/rpcst_dp.sv =====
// tree memories, power tables, range walk and result register
`timescale 1ns / 1ps
module rpcst_dp #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rpcst_pkg::FIELD_W-1:0]     cfg_wdata,
  input  rpcst_pkg::rpcst_in_t              in_item,
  input  rpcst_pkg::rpcst_cmd_t             cmd,
  output rpcst_pkg::rpcst_sts_t             sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rpcst_pkg::rpcst_out_t             out_item
);
  import rpcst_pkg::*;

  localparam int N      = MAX_ELEMENTS;
  localparam int NODE_W = $clog2(2 * N);
  localparam int PW     = $clog2(N + 1);
  localparam int SUM_W  = FIELD_W + $clog2(N);
  localparam int TW     = 2 * FIELD_W;
  localparam int CW     = (SUM_W > TW) ? SUM_W : TW;
  localparam int RST_CNT = (N < 1024) ? N : 1024;

  // storage
  logic [SUM_W-1:0]  sum_mem  [2*N];
  logic [HASH_W-1:0] hash_mem [2*N];
  logic [HASH_W-1:0] pow_mem  [N+1];
  logic [HASH_W-1:0] pref_mem [N+1];

  logic [FIELD_W-1:0] cnt_r;
  logic               op_r, err_r, perm_r;
  logic [FIELD_W-1:0] a_r, b_r, k_r;
  logic [NODE_W-1:0]  node_r, init_r;
  logic [NODE_W:0]    lo_r, hi_r;
  logic               tl_r, th_r;
  logic [SUM_W-1:0]   slo_r, shi_r, s_r, sr0_r, sr1_r;
  logic [HASH_W-1:0]  hlo_r, hhi_r, h_r, hr0_r, hr1_r;
  logic [HASH_W-1:0]  pow_rd_r, pref_rd_r, p_r, q_r;
  logic [TW-1:0]      tri_r;
  logic               out_valid_r;
  rpcst_out_t         out_r;

  logic [FIELD_W-1:0] a_in, b_in, k_w;
  logic               upd_err, qry_err;
  logic [NODE_W:0]    lo_inc, hi_dec, hm1;
  logic [HASH_W-1:0]  p_nxt;

  assign a_in    = in_item.position_or_left;
  assign b_in    = in_item.value_or_right;
  assign upd_err = (a_in == '0) || (a_in > cnt_r) || (b_in == '0) || (b_in > cnt_r);
  assign qry_err = (a_in == '0) || (b_in > cnt_r) || (a_in > b_in);
  assign k_w     = b_r - a_r + FIELD_W'(1);
  assign lo_inc  = lo_r + {{NODE_W{1'b0}}, lo_r[0]};
  assign hi_dec  = hi_r - {{NODE_W{1'b0}}, hi_r[0]};
  assign hm1     = hi_r - (NODE_W+1)'(1);
  // times 11 as 8p + 2p + p
  assign p_nxt   = (p_r << 3) + (p_r << 1) + p_r;

  assign sts.init_last   = (init_r == NODE_W'(2 * N - 1));
  assign sts.err         = err_r;
  assign sts.is_query    = (op_r == OPC_QUERY);
  assign sts.node_zero   = (node_r == '0);
  assign sts.range_empty = (lo_r >= hi_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // element count register, clamped to 1..MAX_ELEMENTS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= FIELD_W'(RST_CNT);
    end else if (cfg_we) begin
      priority if (cfg_wdata == '0) cnt_r <= FIELD_W'(1);
      else if (32'(cfg_wdata) > N) cnt_r <= FIELD_W'(N);
      else cnt_r <= cfg_wdata;
    end
  end

  // init sweep: zero the tree, build power and prefix tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
      p_r    <= HASH_W'(1);
      q_r    <= '0;
    end else if (cmd.init_step) begin
      init_r <= init_r + NODE_W'(1);
      p_r    <= p_nxt;
      q_r    <= q_r + p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step && (32'(init_r) <= N)) begin
      pow_mem[PW'(init_r)]  <= p_r;
      pref_mem[PW'(init_r)] <= q_r;
    end
    if (cmd.decode) begin
      pow_rd_r  <= pow_mem[PW'(b_r)];
      pref_rd_r <= pref_mem[PW'(k_w)];
    end
  end

  // tree memories: one write port, two read ports
  logic              t_we;
  logic [NODE_W-1:0] t_wa, t_ra0, t_ra1;
  logic [SUM_W-1:0]  t_ws;
  logic [HASH_W-1:0] t_wh;

  always_comb begin
    t_we  = cmd.init_step || cmd.leaf_wr || cmd.up_wr;
    t_wa  = cmd.init_step ? init_r : node_r;
    t_ws  = '0;
    t_wh  = '0;
    if (cmd.leaf_wr) begin
      t_ws = SUM_W'(b_r);
      t_wh = pow_rd_r;
    end else if (cmd.up_wr) begin
      t_ws = sr0_r + sr1_r;
      t_wh = hr0_r + hr1_r;
    end
    if (cmd.q_rd) begin
      t_ra0 = lo_r[NODE_W-1:0];
      t_ra1 = hm1[NODE_W-1:0];
    end else begin
      t_ra0 = {node_r[NODE_W-2:0], 1'b0};
      t_ra1 = {node_r[NODE_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      sum_mem[t_wa]  <= t_ws;
      hash_mem[t_wa] <= t_wh;
    end
    if (cmd.up_rd || cmd.q_rd) begin
      sr0_r <= sum_mem[t_ra0];
      sr1_r <= sum_mem[t_ra1];
      hr0_r <= hash_mem[t_ra0];
      hr1_r <= hash_mem[t_ra1];
    end
  end

  // item decode, walk registers and accumulators
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_item.opcode;
      a_r    <= a_in;
      b_r    <= b_in;
      err_r  <= (in_item.opcode == OPC_QUERY) ? qry_err : upd_err;
      perm_r <= 1'b0;
    end
    if (cmd.decode) begin
      node_r <= NODE_W'(N) + NODE_W'(a_r) - NODE_W'(1);
      lo_r   <= (NODE_W+1)'(N) + (NODE_W+1)'(a_r) - (NODE_W+1)'(1);
      hi_r   <= (NODE_W+1)'(N) + (NODE_W+1)'(b_r);
      k_r    <= k_w;
      slo_r  <= '0;
      shi_r  <= '0;
      hlo_r  <= '0;
      hhi_r  <= '0;
    end
    if (cmd.leaf_wr || cmd.up_wr) node_r <= node_r >> 1;
    if (cmd.q_rd) begin
      tl_r <= lo_r[0];
      th_r <= hi_r[0];
      lo_r <= lo_inc >> 1;
      hi_r <= hi_dec >> 1;
    end
    if (cmd.q_acc) begin
      if (tl_r) begin
        slo_r <= slo_r + sr0_r;
        hlo_r <= hlo_r + hr0_r;
      end
      if (th_r) begin
        shi_r <= shi_r + sr1_r;
        hhi_r <= hhi_r + hr1_r;
      end
    end
    if (cmd.fin) begin
      s_r   <= slo_r + shi_r;
      h_r   <= hlo_r + hhi_r;
      tri_r <= TW'(k_r) * (TW'(k_r) + TW'(1));
    end
    if (cmd.cmp) perm_r <= (CW'(s_r) == CW'(tri_r >> 1)) && (h_r == pref_rd_r);
    if (cmd.load_out) begin
      out_r.is_permutation <= perm_r;
      out_r.range_error    <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

endmodule

// ===== src/rpcst_chk.sv =====
// port-level checks for the permutation range checker
`timescale 1ns / 1ps
module rpcst_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input rpcst_pkg::rpcst_out_t out_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // an error result never claims a permutation
  a_err_perm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.range_error && out_item.is_permutation))
    else $error("error with permutation flag");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // clearing pass blocks input right after reset
  a_init_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready during clearing pass");

endmodule

bind range_permutation_check_segment_tree_unit rpcst_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== tb/tb.sv =====
// testbench for the permutation range checker: predictor, driver, monitor
`timescale 1ns / 1ps
module tb;
  import rpcst_pkg::*;

  localparam int MAX_N = 1024;
  localparam int TREE_N = 2 * MAX_N;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rpcst_in_t in_item;
  logic out_valid;
  logic out_ready;
  rpcst_out_t out_item;
  logic cfg_we;
  logic [FIELD_W-1:0] cfg_wdata;

  range_permutation_check_segment_tree_unit #(.MAX_ELEMENTS(MAX_N)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state: shadow tree, tables and the position count
  logic [63:0] sum_nodes [TREE_N];
  logic [63:0] hash_nodes [TREE_N];
  logic [63:0] pow11 [MAX_N+1];
  logic [63:0] pow11_prefix [MAX_N+1];
  int unsigned pos_count;

  rpcst_in_t pending_items[$];
  rpcst_out_t expected_results[$];
  int fail_count;
  bit in_taken;
  bit hold_off;
  bit hold_start;
  bit hold_done;
  bit quiet;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned clamp_count(input logic [FIELD_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_N) return MAX_N;
    return 32'(v);
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < TREE_N; i++) begin
      sum_nodes[i] = '0;
      hash_nodes[i] = '0;
    end
    pow11[0] = 64'd1;
    pow11_prefix[0] = '0;
    for (int i = 1; i <= MAX_N; i++) begin
      pow11[i] = pow11[i-1] * HASH_BASE;
      pow11_prefix[i] = pow11_prefix[i-1] + pow11[i];
    end
    pos_count = MAX_N;
  endfunction

  // apply one item to the shadow tree and return what the block must answer
  function automatic rpcst_out_t predict_answer(input rpcst_in_t it);
    int unsigned a, b, node, lo, hi;
    logic [63:0] s, h, k;
    rpcst_out_t r;
    a = 32'(it.position_or_left);
    b = 32'(it.value_or_right);
    r = '0;
    if (it.opcode == OPC_UPDATE) begin
      if (a < 1 || a > pos_count || b < 1 || b > pos_count) r.range_error = 1'b1;
      else begin
        node = MAX_N + a - 1;
        sum_nodes[node] = 64'(b);
        hash_nodes[node] = pow11[b];
        node = node >> 1;
        while (node >= 1) begin
          sum_nodes[node] = sum_nodes[2*node] + sum_nodes[2*node+1];
          hash_nodes[node] = hash_nodes[2*node] + hash_nodes[2*node+1];
          node = node >> 1;
        end
      end
    end else begin
      if (a < 1 || b > pos_count || a > b) r.range_error = 1'b1;
      else begin
        lo = MAX_N + a - 1;
        hi = MAX_N + b;
        s = '0;
        h = '0;
        k = 64'(b - a + 1);
        while (lo < hi) begin
          if (lo[0]) begin s += sum_nodes[lo]; h += hash_nodes[lo]; lo++; end
          if (hi[0]) begin hi--; s += sum_nodes[hi]; h += hash_nodes[hi]; end
          lo = lo >> 1;
          hi = hi >> 1;
        end
        r.is_permutation = (s == k * (k + 1) / 2) && (h == pow11_prefix[k]);
      end
    end
    return r;
  endfunction

  function automatic void push_item(input logic opc, input int unsigned a,
                                    input int unsigned b);
    rpcst_in_t it;
    it.opcode = opc;
    it.position_or_left = a[FIELD_W-1:0];
    it.value_or_right = b[FIELD_W-1:0];
    pending_items = {pending_items, it};
  endfunction

  // permutation of 1..k (one entry optionally spoiled) written at [base, base+k-1], then queries over it
  function automatic void push_perm_block(input int unsigned base, input int unsigned k,
                                          input bit spoil);
    int unsigned vals[$];
    int unsigned j, t;
    for (int unsigned i = 1; i <= k; i++) vals = {vals, i};
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = vals[i]; vals[i] = vals[j]; vals[j] = t;
    end
    if (spoil) vals[$urandom_range(k-1, 0)] = $urandom_range(k, 1);
    for (int unsigned i = 0; i < k; i++) push_item(OPC_UPDATE, base + i, vals[i]);
    push_item(OPC_QUERY, base, base + k - 1);
    push_item(OPC_QUERY, base, base + $urandom_range(k-1, 0));
  endfunction

  // noise: any field value, well-formed or not
  function automatic void push_noise();
    push_item(1'($urandom_range(1, 0)), $urandom_range(2047, 0), $urandom_range(2047, 0));
  endfunction

  // driver: new item offered at the falling edge, held until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (in_valid && !in_taken) begin
      // hold the item
    end else if (pending_items.size() != 0 && (quiet || $urandom_range(99, 0) >= 9)) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // acceptance bookkeeping, at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_results = {expected_results, predict_answer(in_item)};
  end

  // receiver ready, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && (quiet || $urandom_range(99, 0) >= 9);
  end

  // long receiver hold-off, counted here once started
  initial begin
    hold_off = 1'b0;
    hold_done = 1'b0;
    wait (hold_start);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    hold_done = 1'b1;
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    rpcst_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.is_permutation !== exp_r.is_permutation)
          report_mismatch($sformatf("is_permutation %b, expected %b",
                                    out_item.is_permutation, exp_r.is_permutation));
        if (out_item.range_error !== exp_r.range_error)
          report_mismatch($sformatf("range_error %b, expected %b",
                                    out_item.range_error, exp_r.range_error));
      end
    end
  end

  // wait until every queued item is sent and every answer has come back
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [FIELD_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    pos_count = clamp_count(v);
  endtask

  function automatic void push_random_phase(input int n);
    int unsigned k, base;
    int made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99, 0) < 75) begin
        // mostly short blocks, a few longer ones
        k = ($urandom_range(19, 0) == 0) ? $urandom_range(pos_count < 64 ? pos_count : 64, 1)
                                          : $urandom_range(pos_count < 8 ? pos_count : 8, 1);
        base = $urandom_range(pos_count - k + 1, 1);
        push_perm_block(base, k, $urandom_range(3, 0) == 0);
        made += k + 2;
      end else begin
        push_noise();
        made++;
      end
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_start = 1'b0;
    quiet = 1'b0;
    fail_count = 0;
    clear_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: untouched tree, field extremes, every error case
    push_item(OPC_QUERY, 1, 1);
    push_item(OPC_QUERY, 1, MAX_N);
    push_item(OPC_UPDATE, 1, 1);
    push_item(OPC_QUERY, 1, 1);
    push_item(OPC_UPDATE, MAX_N, MAX_N);
    push_item(OPC_QUERY, MAX_N, MAX_N);
    push_item(OPC_UPDATE, 0, 5);
    push_item(OPC_UPDATE, 5, 0);
    push_item(OPC_UPDATE, 2047, 3);
    push_item(OPC_UPDATE, 3, 2047);
    push_item(OPC_UPDATE, MAX_N + 1, 1);
    push_item(OPC_QUERY, 0, 4);
    push_item(OPC_QUERY, 4, 3);
    push_item(OPC_QUERY, 1, MAX_N + 1);
    push_item(OPC_QUERY, 2047, 2047);
    push_item(OPC_UPDATE, 2, 2);
    push_item(OPC_QUERY, 1, 2);
    push_item(OPC_UPDATE, 2, 1);
    push_item(OPC_QUERY, 1, 2);
    push_item(OPC_UPDATE, 1, 2);
    push_item(OPC_QUERY, 1, 2);
    drain();

    // small count: zero is taken as one
    write_count('0);
    push_item(OPC_UPDATE, 1, 1);
    push_item(OPC_UPDATE, 2, 1);
    push_item(OPC_UPDATE, 1, 2);
    push_item(OPC_QUERY, 1, 1);
    push_item(OPC_QUERY, 1, 2);
    push_random_phase(30);
    drain();

    // shrunk count, stale positions beyond it stay but are unreachable
    write_count(11'd16);
    push_random_phase(200);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_count(11'd8);
    push_random_phase(40);
    hold_start = 1'b1;
    wait (hold_done);
    drain();

    // saturating write with a quiet stretch, then full size and a mid count with stalls
    write_count(11'h7FF);
    quiet = 1'b1;
    push_random_phase(150);
    drain();
    quiet = 1'b0;
    write_count(11'd1024);
    push_random_phase(150);
    drain();
    write_count(11'd300);
    push_random_phase(250);
    drain();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog: clearing pass plus about 900 items with stalls
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
